@@ rtl/fltrail_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fltrail_pkg
// Shared types, constants and helpers for the fading line trail store.
// ----------------------------------------------------------------------------
package fltrail_pkg;

	localparam int MaxSegments = 32;
	localparam int IdxW = $clog2(MaxSegments);
	localparam int CntW = $clog2(MaxSegments + 1);
	localparam int OutLimit = 32;

	localparam logic [2:0] OP_MOVE = 3'd0;
	localparam logic [2:0] OP_BEGIN = 3'd1;
	localparam logic [2:0] OP_ALPHA = 3'd2;
	localparam logic [2:0] OP_COLOR = 3'd3;
	localparam logic [2:0] OP_READ = 3'd4;

	localparam logic KIND_RECT = 1'b0;
	localparam logic KIND_SEG = 1'b1;

	typedef struct packed {
		logic        kind;
		logic [15:0] x0;
		logic [15:0] y0;
		logic [15:0] x1;
		logic [15:0] y1;
		logic [31:0] color;
		logic        last;
	} result_t;

	function automatic logic [7:0] step_toward(input logic [7:0] c, input logic [7:0] t,
		input logic [7:0] s);
		logic [8:0] up;
		logic [8:0] lim;
		begin
			up = {1'b0, c} + {1'b0, s};
			lim = {1'b0, t} + {1'b0, s};
			if (c < t)
				step_toward = (up >= {1'b0, t}) ? t : up[7:0];
			else if (c > t)
				step_toward = ({1'b0, c} <= lim) ? t : c - s;
			else
				step_toward = c;
		end
	endfunction

endpackage

@@ rtl/fltrail_fade.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fltrail_fade
// Shared fade unit: ages one segment color and reports whether it is gone.
// ----------------------------------------------------------------------------
module fltrail_fade (
	input  logic        color_tick,
	input  logic [31:0] color_in,
	input  logic [31:0] fade_color,
	input  logic [7:0]  fade_step,
	output logic [31:0] color_out,
	output logic        gone
);
	import fltrail_pkg::*;

	logic [7:0] r, g, b, a;

	always_comb begin
		r = step_toward(color_in[31:24], fade_color[31:24], fade_step);
		g = step_toward(color_in[23:16], fade_color[23:16], fade_step);
		b = step_toward(color_in[15:8], fade_color[15:8], fade_step);
		a = (color_in[7:0] <= fade_step) ? 8'd0 : color_in[7:0] - fade_step;
		if (color_tick) begin
			color_out = {r, g, b, color_in[7:0]};
			gone = (r == fade_color[31:24]) && (g == fade_color[23:16])
				&& (b == fade_color[15:8]);
		end else begin
			color_out = {color_in[31:8], a};
			gone = (a == 8'd0);
		end
	end
endmodule

@@ rtl/fading_line_trail_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fading_line_trail_store
// Segment store walked one entry at a time by a small sequencer.
// Begin sets the anchor. Move appends a segment and emits its box; when the
// store is full the oldest segment is dropped by walking the store once.
// Tick fades and compacts each segment, then emits their bounding box; readout
// emits each segment in turn. Each result is registered as the sequencer leaves
// the emit state; a stalled result holds the sequencer. One request at a time.
// Reset clears the count, anchor and registers; the memory is not cleared.
// ----------------------------------------------------------------------------
module fading_line_trail_store (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  operation,
	input  logic signed [15:0] x,
	input  logic signed [15:0] y,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        kind,
	output logic signed [15:0] x0,
	output logic signed [15:0] y0,
	output logic signed [15:0] x1,
	output logic signed [15:0] y1,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic [7:0]  alpha,
	output logic        last,
	output logic [5:0]  segment_count
);
	import fltrail_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RD   = 3'd1;
	localparam logic [2:0] S_PROC = 3'd2;
	localparam logic [2:0] S_EMIT = 3'd3;
	localparam logic [2:0] S_WAIT = 3'd4;
	localparam logic [2:0] S_WR   = 3'd5;

	logic [31:0] line_color_q, fade_color_q;
	logic [7:0]  fade_step_q;
	logic [63:0] ends_mem [MaxSegments];
	logic [31:0] cols_mem [MaxSegments];
	logic [63:0] e_q;
	logic [31:0] c_q;
	logic [2:0]  state_q, op_q;
	logic [CntW-1:0] held_q, k_q, kept_q;
	logic [15:0] ax_q, ay_q, px_q, py_q;
	logic        av_q;
	logic [15:0] ul_q, ut_q, ur_q, ub_q;
	logic        ovalid_q;
	result_t     res_q;
	logic [5:0]  cnt_q;
	logic        shift_q;
	logic [31:0] fcol;
	logic        gone;
	logic signed [15:0] ex0, ey0, ex1, ey1, l, r, t, b;
	logic        wr_en;
	logic [IdxW-1:0] wr_idx;
	logic [63:0] wr_e;
	logic [31:0] wr_c;
	logic [CntW-1:0] rd_k;
	logic [CntW-1:0] stop_k;

	assign pready = 1'b1;
	always_comb begin
		unique case (paddr[3:2])
			2'd0: prdata = line_color_q;
			2'd1: prdata = fade_color_q;
			2'd2: prdata = {24'd0, fade_step_q};
			default: prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_color_q <= 32'hFF000000;
			fade_color_q <= 32'hFFFFFFFF;
			fade_step_q <= 8'd16;
		end else if (psel && penable && pwrite) begin
			if (paddr[3:2] == 2'd0) line_color_q <= pwdata;
			if (paddr[3:2] == 2'd1) fade_color_q <= pwdata;
			if (paddr[3:2] == 2'd2) fade_step_q <= pwdata[7:0];
		end
	end

	fltrail_fade u_fade (
		.color_tick(op_q == OP_COLOR),
		.color_in  (c_q),
		.fade_color(fade_color_q),
		.fade_step (fade_step_q),
		.color_out (fcol),
		.gone      (gone)
	);

	assign ex0 = e_q[63:48];
	assign ey0 = e_q[47:32];
	assign ex1 = e_q[31:16];
	assign ey1 = e_q[15:0];
	assign l = (ex0 < ex1) ? ex0 : ex1;
	assign r = (ex0 < ex1) ? ex1 : ex0;
	assign t = (ey0 < ey1) ? ey0 : ey1;
	assign b = (ey0 < ey1) ? ey1 : ey0;

	assign in_stall = (state_q != S_IDLE);
	assign rd_k = k_q;

	always_comb begin
		if (op_q == OP_READ && held_q > CntW'(OutLimit))
			stop_k = CntW'(OutLimit);
		else
			stop_k = held_q;
	end

	// Memory write mux: shift-down on full move, compaction on tick, append.
	always_comb begin
		wr_en = 1'b0;
		wr_idx = kept_q[IdxW-1:0];
		wr_e = e_q;
		wr_c = c_q;
		if (state_q == S_PROC) begin
			if (shift_q) begin
				wr_en = (k_q != '0);
				wr_idx = IdxW'(k_q - 1'b1);
			end else if (op_q == OP_ALPHA || op_q == OP_COLOR) begin
				wr_en = !gone;
				wr_c = fcol;
			end
		end else if (state_q == S_WR) begin
			wr_en = 1'b1;
			wr_idx = kept_q[IdxW-1:0];
			wr_e = {ax_q, ay_q, px_q, py_q};
			wr_c = line_color_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			ends_mem[wr_idx] <= wr_e;
			cols_mem[wr_idx] <= wr_c;
		end
		if (state_q == S_RD) begin
			e_q <= ends_mem[rd_k[IdxW-1:0]];
			c_q <= cols_mem[rd_k[IdxW-1:0]];
		end else if (state_q == S_WR) begin
			e_q <= {ax_q, ay_q, px_q, py_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q <= OP_MOVE;
			held_q <= '0;
			k_q <= '0;
			kept_q <= '0;
			ax_q <= '0;
			ay_q <= '0;
			px_q <= '0;
			py_q <= '0;
			av_q <= 1'b0;
			ul_q <= '0;
			ut_q <= '0;
			ur_q <= '0;
			ub_q <= '0;
			ovalid_q <= 1'b0;
			res_q <= '0;
			cnt_q <= '0;
			shift_q <= 1'b0;
		end else begin
			if (ovalid_q && !out_stall && state_q != S_EMIT) ovalid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q <= operation;
						px_q <= x;
						py_q <= y;
						k_q <= '0;
						kept_q <= '0;
						shift_q <= 1'b0;
						priority if (operation == OP_BEGIN) begin
							ax_q <= x;
							ay_q <= y;
							av_q <= 1'b1;
						end else if (operation == OP_MOVE) begin
							if (!av_q) begin
								ax_q <= x;
								ay_q <= y;
								av_q <= 1'b1;
							end else if (held_q >= CntW'(MaxSegments)) begin
								shift_q <= 1'b1;
								state_q <= S_RD;
							end else begin
								kept_q <= held_q;
								state_q <= S_WR;
							end
						end else if ((operation == OP_ALPHA || operation == OP_COLOR
							|| operation == OP_READ) && held_q != '0) begin
							state_q <= S_RD;
						end
					end
				end
				S_RD: state_q <= S_PROC;
				S_PROC: begin
					k_q <= k_q + 1'b1;
					if (shift_q) begin
						if (k_q == held_q - 1'b1) begin
							kept_q <= CntW'(MaxSegments - 1);
							state_q <= S_WR;
						end else begin
							state_q <= S_RD;
						end
					end else if (op_q == OP_READ) begin
						state_q <= S_EMIT;
					end else begin
						if (k_q == '0) begin
							ul_q <= l; ut_q <= t; ur_q <= r; ub_q <= b;
						end else begin
							if (l < $signed(ul_q)) ul_q <= l;
							if (t < $signed(ut_q)) ut_q <= t;
							if (r > $signed(ur_q)) ur_q <= r;
							if (b > $signed(ub_q)) ub_q <= b;
						end
						if (!gone) kept_q <= kept_q + 1'b1;
						if (k_q + 1'b1 == stop_k) state_q <= S_EMIT;
						else state_q <= S_RD;
					end
				end
				S_EMIT: begin
					if (!ovalid_q || !out_stall) begin
						ovalid_q <= 1'b1;
						if (op_q == OP_READ) begin
							res_q <= '{KIND_SEG, ex0, ey0, ex1, ey1, c_q, k_q == stop_k};
							cnt_q <= 6'(held_q);
							state_q <= (k_q == stop_k) ? S_IDLE : S_RD;
						end else if (op_q == OP_MOVE) begin
							res_q <= '{KIND_RECT, l, t, r, b, 32'd0, 1'b1};
							cnt_q <= 6'(held_q);
							ax_q <= px_q;
							ay_q <= py_q;
							state_q <= S_IDLE;
						end else begin
							res_q <= '{KIND_RECT, ul_q, ut_q, ur_q, ub_q, 32'd0, 1'b1};
							cnt_q <= 6'(kept_q);
							held_q <= kept_q;
							state_q <= S_IDLE;
						end
					end
				end
				S_WR: begin
					held_q <= kept_q + 1'b1;
					shift_q <= 1'b0;
					state_q <= S_WAIT;
				end
				S_WAIT: state_q <= S_EMIT;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = ovalid_q;
	assign kind = res_q.kind;
	assign x0 = res_q.x0;
	assign y0 = res_q.y0;
	assign x1 = res_q.x1;
	assign y1 = res_q.y1;
	assign red = res_q.color[31:24];
	assign green = res_q.color[23:16];
	assign blue = res_q.color[15:8];
	assign alpha = res_q.color[7:0];
	assign last = res_q.last;
	assign segment_count = cnt_q;
endmodule

@@ tb/sv/trail_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trail_checker
// Watches the request, result and register channels of the fading line trail
// store, predicts every result from its own copy of the segment list and the
// registers, and compares each result, field by field, in order.
// ----------------------------------------------------------------------------
module trail_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [2:0]  operation,
	input  logic signed [15:0] x,
	input  logic signed [15:0] y,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic        kind,
	input  logic signed [15:0] x0,
	input  logic signed [15:0] y0,
	input  logic signed [15:0] x1,
	input  logic signed [15:0] y1,
	input  logic [7:0]  red,
	input  logic [7:0]  green,
	input  logic [7:0]  blue,
	input  logic [7:0]  alpha,
	input  logic        last,
	input  logic [5:0]  segment_count,
	output int          fail_count,
	output int          pending
);
	import fltrail_pkg::*;

	typedef struct {
		logic              kind;
		logic signed [15:0] x0, y0, x1, y1;
		logic [31:0]       color;
		logic              last;
		logic [5:0]        count;
	} trail_result_t;

	typedef struct {
		logic signed [15:0] ax, ay, bx, by;
		logic [31:0]       color;
	} segment_t;

	trail_result_t expected_results[$];
	segment_t      trail[$];
	logic [31:0]   line_color_r, fade_color_r;
	logic [7:0]    fade_step_r;
	logic signed [15:0] anchor_x, anchor_y;
	logic          anchor_valid;

	function automatic logic [7:0] move_toward(logic [7:0] c, logic [7:0] t, logic [7:0] s);
		int ci, ti, si;
		ci = c; ti = t; si = s;
		if (ci < ti) return (ci + si >= ti) ? t : 8'(ci + si);
		if (ci > ti) return (ci <= ti + si) ? t : 8'(ci - si);
		return c;
	endfunction

	task automatic predict_request(logic [2:0] op, logic signed [15:0] px,
		logic signed [15:0] py);
		trail_result_t r;
		segment_t s, kept[$];
		logic signed [15:0] l, t, rr, b, ul, ut, ur, ub;
		logic [7:0] a, cr, cg, cb;
		logic gone;
		r = '{default: '0};
		if (op == OP_BEGIN) begin
			anchor_x = px; anchor_y = py; anchor_valid = 1;
		end else if (op == OP_MOVE) begin
			if (anchor_valid) begin
				if (trail.size() >= MaxSegments) void'(trail.pop_front());
				s = '{anchor_x, anchor_y, px, py, line_color_r};
				trail.insert(trail.size(), s);
				r.x0 = (anchor_x < px) ? anchor_x : px;
				r.x1 = (anchor_x < px) ? px : anchor_x;
				r.y0 = (anchor_y < py) ? anchor_y : py;
				r.y1 = (anchor_y < py) ? py : anchor_y;
				r.kind = KIND_RECT; r.last = 1; r.count = 6'(trail.size());
				expected_results.insert(expected_results.size(), r);
			end
			anchor_x = px; anchor_y = py; anchor_valid = 1;
		end else if ((op == OP_ALPHA || op == OP_COLOR) && trail.size() > 0) begin
			foreach (trail[k]) begin
				s = trail[k];
				l = (s.ax < s.bx) ? s.ax : s.bx; rr = (s.ax < s.bx) ? s.bx : s.ax;
				t = (s.ay < s.by) ? s.ay : s.by; b = (s.ay < s.by) ? s.by : s.ay;
				if (k == 0) begin
					ul = l; ut = t; ur = rr; ub = b;
				end else begin
					if (l < ul) ul = l;
					if (t < ut) ut = t;
					if (rr > ur) ur = rr;
					if (b > ub) ub = b;
				end
				if (op == OP_ALPHA) begin
					a = s.color[7:0];
					a = (a <= fade_step_r) ? 8'd0 : a - fade_step_r;
					s.color[7:0] = a;
					gone = (a == 0);
				end else begin
					cr = move_toward(s.color[31:24], fade_color_r[31:24], fade_step_r);
					cg = move_toward(s.color[23:16], fade_color_r[23:16], fade_step_r);
					cb = move_toward(s.color[15:8], fade_color_r[15:8], fade_step_r);
					s.color[31:8] = {cr, cg, cb};
					gone = (s.color[31:8] == fade_color_r[31:8]);
				end
				if (!gone) kept.insert(kept.size(), s);
			end
			trail = kept;
			r = '{KIND_RECT, ul, ut, ur, ub, 32'd0, 1'b1, 6'(trail.size())};
			expected_results.insert(expected_results.size(), r);
		end else if (op == OP_READ) begin
			foreach (trail[k]) begin
				if (k < OutLimit) begin
					r = '{KIND_SEG, trail[k].ax, trail[k].ay, trail[k].bx, trail[k].by,
						trail[k].color, 1'b0, 6'(trail.size())};
					r.last = (k == trail.size() - 1 || k == OutLimit - 1);
					expected_results.insert(expected_results.size(), r);
				end
			end
		end
	endtask

	task automatic check_field(string name, longint exp_v, longint act_v);
		if (exp_v != act_v) begin
			$error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		trail_result_t e;
		if (!arst_n) begin
			line_color_r <= 32'hFF000000;
			fade_color_r <= 32'hFFFFFFFF;
			fade_step_r <= 8'd16;
			anchor_valid = 0; anchor_x = 0; anchor_y = 0;
			trail.delete();
			expected_results.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (psel && penable && pwrite) begin
				case (paddr)
					4'd0: line_color_r <= pwdata;
					4'd4: fade_color_r <= pwdata;
					4'd8: fade_step_r <= pwdata[7:0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					$error("Unexpected result: kind %0d x0 %0d", kind, x0);
					fail_count++;
				end else begin
					e = expected_results.pop_front();
					check_field("kind", e.kind, kind);
					check_field("x0", e.x0, x0);
					check_field("y0", e.y0, y0);
					check_field("x1", e.x1, x1);
					check_field("y1", e.y1, y1);
					check_field("red", e.color[31:24], red);
					check_field("green", e.color[23:16], green);
					check_field("blue", e.color[15:8], blue);
					check_field("alpha", e.color[7:0], alpha);
					check_field("last", e.last, last);
					check_field("segment_count", e.count, segment_count);
				end
			end
			if (in_valid && !in_stall) predict_request(operation, x, y);
			pending = expected_results.size();
		end
	end

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the fading line trail store: directed corner requests, then
// random moves, begins, ticks, reads and bad opcodes under several register
// settings, with random idling on both channels and a long result hold-off.
// ----------------------------------------------------------------------------
module tb;
	import fltrail_pkg::*;

	logic clk = 0, arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [3:0] paddr = 0;
	logic [31:0] pwdata = 0, prdata;
	logic pready;
	logic in_valid = 0, in_stall;
	logic [2:0] operation = 0;
	logic signed [15:0] x = 0, y = 0;
	logic out_valid, out_stall = 0;
	logic kind, last;
	logic signed [15:0] x0, y0, x1, y1;
	logic [7:0] red, green, blue, alpha;
	logic [5:0] segment_count;
	int fail_count, pending;
	int hold_cycles = 0;
	bit hold_req = 0;
	bit hold_done = 0;
	bit no_idle = 0;

	always #10 clk = ~clk;

	fading_line_trail_store DUT (.*);
	trail_checker u_checker (.*);

	always @(posedge clk) begin
		if (hold_req && !hold_done) begin
			out_stall <= 1;
			hold_cycles <= 600;
			hold_done <= 1;
		end else if (hold_cycles > 0) begin
			out_stall <= 1;
			hold_cycles <= hold_cycles - 1;
		end else
			out_stall <= no_idle ? 1'b0 : ($urandom_range(99) < 31);
	end

	task automatic reg_write(logic [3:0] addr, logic [31:0] value);
		@(posedge clk);
		psel <= 1; pwrite <= 1; penable <= 0; paddr <= addr; pwdata <= value;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
	endtask

	task automatic send_request(logic [2:0] op, logic signed [15:0] px,
		logic signed [15:0] py);
		while (!no_idle && $urandom_range(99) < 31) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1; operation <= op; x <= px; y <= py;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic drain;
		in_valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	function automatic logic signed [15:0] rand_coord;
		case ($urandom_range(3))
			0: return 16'($urandom);
			1: return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
			default: return 16'($urandom_range(400)) - 16'sd200;
		endcase
	endfunction

	task automatic random_phase(int n);
		int r;
		repeat (n) begin
			r = $urandom_range(99);
			if (r < 55) send_request(OP_MOVE, rand_coord(), rand_coord());
			else if (r < 62) send_request(OP_BEGIN, rand_coord(), rand_coord());
			else if (r < 74) send_request(OP_ALPHA, 16'($urandom), 16'($urandom));
			else if (r < 86) send_request(OP_COLOR, 16'($urandom), 16'($urandom));
			else if (r < 96) send_request(OP_READ, 16'($urandom), 16'($urandom));
			else send_request(3'($urandom_range(7, 5)), 16'($urandom), 16'($urandom));
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		send_request(OP_ALPHA, 0, 0);
		send_request(OP_READ, 0, 0);
		send_request(3'd5, 0, 0);
		send_request(3'd7, -1, -1);
		send_request(OP_MOVE, 16'sh7FFF, 16'sh8000);
		send_request(OP_MOVE, 16'sh8000, 16'sh7FFF);
		send_request(OP_BEGIN, 0, 0);
		send_request(OP_MOVE, -1, 1);
		send_request(OP_READ, 0, 0);
		send_request(OP_COLOR, 0, 0);
		send_request(OP_ALPHA, 0, 0);
		send_request(OP_READ, 0, 0);
		drain();
		reg_write(4'd0, 32'h12345601);
		reg_write(4'd4, 32'h00000000);
		reg_write(4'd8, 32'd0);
		send_request(OP_MOVE, 5, 5);
		send_request(OP_MOVE, 6, -7);
		send_request(OP_ALPHA, 0, 0);
		send_request(OP_COLOR, 0, 0);
		send_request(OP_READ, 0, 0);
		drain();
		reg_write(4'd8, 32'd255);
		send_request(OP_COLOR, 0, 0);
		send_request(OP_ALPHA, 0, 0);
		drain();
		reg_write(4'd0, 32'hFFFFFFFF);
		reg_write(4'd4, 32'h80808000);
		reg_write(4'd8, 32'd40);
		no_idle = 1;
		random_phase(60);
		no_idle = 0;
		hold_req = 1;
		repeat (40) send_request(OP_MOVE, rand_coord(), rand_coord());
		send_request(OP_READ, 0, 0);
		drain();
		reg_write(4'd0, $urandom);
		reg_write(4'd4, $urandom);
		reg_write(4'd8, $urandom_range(1, 30));
		random_phase(150);
		drain();
		reg_write(4'd0, 32'h00000000);
		reg_write(4'd4, $urandom);
		reg_write(4'd8, 32'd1);
		random_phase(70);
		drain();
		reg_write(4'd0, $urandom);
		reg_write(4'd8, $urandom_range(255));
		random_phase(70);
		drain();
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#20ms;
		$display("Verification failed");
		$finish;
	end

endmodule
